>>> design/dpw_pkg.sv
// ----------------------------------------------------------------------------
// dpw_pkg
// Shared types and constants of the gray-scale window/level pixel mapper.
// ----------------------------------------------------------------------------
package dpw_pkg;

	localparam int RAW_W      = 32;             // raw sample bits
	localparam int VAL_W      = RAW_W + 1;      // extended sample, signed
	localparam int RES_W      = 64;             // rescaled value, signed
	localparam int DIV_W      = 31;             // window divisor
	localparam int NUM_W      = DIV_W + 8;      // divisor times 255
	localparam int GRAY_W     = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [GRAY_W-1:0] GRAY_MAX = 8'd255;

	// pixel format codes
	localparam logic [2:0] FMT_PASS8 = 3'd0;
	localparam logic [2:0] FMT_U16   = 3'd1;
	localparam logic [2:0] FMT_S16   = 3'd2;
	localparam logic [2:0] FMT_U32   = 3'd3;
	localparam logic [2:0] FMT_S32   = 3'd4;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PIXEL_FORMAT      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STORED_BITS       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PAD_VALUE         = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RESCALE_SLOPE     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_RESCALE_INTERCEPT = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_WIDTH      = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_CENTER     = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_INVERT_OUTPUT     = 3'd7;

	// how an item's gray value is formed at the end of the pipe
	typedef enum logic [2:0] {
		KIND_PASS,    // low byte, no inversion
		KIND_ZERO,    // padding or bad format, no inversion
		KIND_MAP,     // still being rescaled
		KIND_LEVEL,   // saturated window level, inversion applies
		KIND_DIV      // divider quotient, inversion applies
	} kind_t;

	typedef struct packed {
		logic [2:0]              pixel_format;
		logic [5:0]              stored_bits;
		logic signed [31:0]      pad_value;
		logic signed [31:0]      rescale_slope;
		logic signed [31:0]      rescale_intercept;
		logic [30:0]             window_width;
		logic signed [30:0]      window_center;
		logic                    invert_output;
	} cfg_t;

	typedef struct packed {
		logic signed [31:0] hi;
		logic signed [31:0] lo;
		logic [DIV_W-1:0]   divisor;
	} win_t;

	typedef struct packed {
		kind_t                   kind;
		logic [GRAY_W-1:0]       level;
		logic signed [VAL_W-1:0] val;
		logic                    frame_end;
	} smp_t;

	typedef struct packed {
		kind_t                   kind;
		logic [GRAY_W-1:0]       level;
		logic signed [RES_W-1:0] val;
		logic                    frame_end;
	} res_t;

	typedef struct packed {
		kind_t             kind;
		logic [GRAY_W-1:0] level;
		logic [NUM_W-1:0]  rem;
		logic [GRAY_W-1:0] quo;
		logic              frame_end;
	} div_t;

endpackage

>>> design/dpw_ifs.sv
// ----------------------------------------------------------------------------
// dpw interfaces
// Valid/ready channels for samples, gray results and register writes.
// ----------------------------------------------------------------------------
interface dpw_sample_if import dpw_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [RAW_W-1:0] raw_sample;
	logic             frame_end_in;

	modport source(output valid, raw_sample, frame_end_in, input ready);
	modport sink(input valid, raw_sample, frame_end_in, output ready);
endinterface

interface dpw_gray_if import dpw_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [GRAY_W-1:0] gray_value;
	logic              frame_end_out;

	modport source(output valid, gray_value, frame_end_out, input ready);
	modport sink(input valid, gray_value, frame_end_out, output ready);
endinterface

interface dpw_cfg_if import dpw_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

>>> design/dpw_decode.sv
// ----------------------------------------------------------------------------
// dpw_decode
// Stage 1: format extension, padding match and stored-bits mask.
// ----------------------------------------------------------------------------
module dpw_decode import dpw_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  cfg_t             cfg,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [RAW_W-1:0] raw_sample,
	input  logic             frame_end_in,
	output logic             out_valid,
	input  logic             out_ready,
	output smp_t             out_data
);

	logic signed [VAL_W-1:0] ext;
	logic signed [VAL_W-1:0] pad_ext;
	logic [RAW_W-1:0]        mask;
	logic                    fmt_ok;
	logic                    pos;
	smp_t                    nxt;
	logic                    en_s1;
	logic                    v_s1;
	smp_t                    d_s1;

	always_comb begin
		fmt_ok = 1'b1;
		case (cfg.pixel_format)
			FMT_U16: ext = {{(VAL_W-16){1'b0}}, raw_sample[15:0]};
			FMT_S16: ext = {{(VAL_W-16){raw_sample[15]}}, raw_sample[15:0]};
			FMT_U32: ext = {1'b0, raw_sample};
			FMT_S32: ext = {raw_sample[RAW_W-1], raw_sample};
			default: begin
				ext    = '0;
				fmt_ok = 1'b0;
			end
		endcase
	end

	assign pad_ext = {cfg.pad_value[31], cfg.pad_value};
	// stored_bits of 32 and up keeps the whole word
	assign mask    = cfg.stored_bits[5] ? '1
	               : ((RAW_W'(1) << cfg.stored_bits[4:0]) - RAW_W'(1));
	assign pos     = !ext[VAL_W-1] && (ext != '0);

	always_comb begin
		nxt.level     = raw_sample[GRAY_W-1:0];
		nxt.frame_end = frame_end_in;
		nxt.val       = pos ? {1'b0, ext[RAW_W-1:0] & mask} : ext;
		if (cfg.pixel_format == FMT_PASS8) begin
			nxt.kind = KIND_PASS;
		end else if (!fmt_ok || ext == pad_ext) begin
			nxt.kind = KIND_ZERO;
		end else begin
			nxt.kind = KIND_MAP;
		end
	end

	assign en_s1    = !v_s1 || out_ready;
	assign in_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en_s1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && in_valid) begin
			d_s1 <= nxt;
		end
	end

	assign out_valid = v_s1;
	assign out_data  = d_s1;

	// negative samples skip the mask and are sign-extended words
	a_sign_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && d_s1.kind == KIND_MAP && d_s1.val[VAL_W-1] |-> d_s1.val[RAW_W-1])
		else $error("decode: negative sample outside the 32-bit signed range");

endmodule

>>> design/dpw_rescale.sv
// ----------------------------------------------------------------------------
// dpw_rescale
// Stages 2 and 3: slope multiply, then intercept add in 64 bits.
// ----------------------------------------------------------------------------
module dpw_rescale import dpw_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  cfg_t cfg,
	input  logic in_valid,
	output logic in_ready,
	input  smp_t in_data,
	output logic out_valid,
	input  logic out_ready,
	output res_t out_data
);

	logic signed [31:0]        slope;
	logic signed [VAL_W-1:0]   sval;
	logic signed [VAL_W+31:0]  prod;
	logic signed [RES_W-1:0]   icpt;
	logic                      en_s2;
	logic                      en_s3;
	logic                      v_s2;
	logic                      v_s3;
	res_t                      d_s2;
	res_t                      d_s3;

	assign slope = cfg.rescale_slope;
	assign sval  = in_data.val;
	assign prod  = slope * sval;
	assign icpt  = cfg.rescale_intercept;

	assign en_s3    = !v_s3 || out_ready;
	assign en_s2    = !v_s2 || en_s3;
	assign in_ready = en_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en_s2) begin
				v_s2 <= in_valid;
			end
			if (en_s3) begin
				v_s3 <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2 && in_valid) begin
			d_s2.kind      <= in_data.kind;
			d_s2.level     <= in_data.level;
			d_s2.frame_end <= in_data.frame_end;
			d_s2.val       <= prod[RES_W-1:0];
		end
		if (en_s3 && v_s2) begin
			d_s3.kind      <= d_s2.kind;
			d_s3.level     <= d_s2.level;
			d_s3.frame_end <= d_s2.frame_end;
			d_s3.val       <= d_s2.val + icpt;
		end
	end

	assign out_valid = v_s3;
	assign out_data  = d_s3;

endmodule

>>> design/dpw_window.sv
// ----------------------------------------------------------------------------
// dpw_window
// Stage 4: window compare, saturation and divider numerator.
// ----------------------------------------------------------------------------
module dpw_window import dpw_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  win_t win,
	input  logic in_valid,
	output logic in_ready,
	input  res_t in_data,
	output logic out_valid,
	input  logic out_ready,
	output div_t out_data
);

	logic signed [RES_W-1:0] val;
	logic signed [RES_W-1:0] hi64;
	logic signed [RES_W-1:0] lo64;
	logic                    above;
	logic                    below;
	logic [DIV_W-1:0]        diff;
	logic [NUM_W-1:0]        num;
	div_t                    nxt;
	logic                    en_s4;
	logic                    v_s4;
	div_t                    d_s4;

	assign val   = in_data.val;
	assign hi64  = win.hi;
	assign lo64  = win.lo;
	assign above = val > hi64;
	assign below = val <= lo64;
	// inside the window val - lo is below 2^31, so the low bits are enough
	assign diff  = val[DIV_W-1:0] - win.lo[DIV_W-1:0];
	assign num   = {diff, 8'd0} - {8'd0, diff};

	always_comb begin
		nxt.kind      = in_data.kind;
		nxt.level     = in_data.level;
		nxt.frame_end = in_data.frame_end;
		nxt.rem       = num;
		nxt.quo       = '0;
		if (in_data.kind == KIND_MAP) begin
			if (above) begin
				nxt.kind  = KIND_LEVEL;
				nxt.level = GRAY_MAX;
			end else if (below) begin
				nxt.kind  = KIND_LEVEL;
				nxt.level = '0;
			end else begin
				nxt.kind  = KIND_DIV;
			end
		end
	end

	assign en_s4    = !v_s4 || out_ready;
	assign in_ready = en_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en_s4) begin
			v_s4 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s4 && in_valid) begin
			d_s4 <= nxt;
		end
	end

	assign out_valid = v_s4;
	assign out_data  = d_s4;

	// numerator must give an 8-bit quotient for the divider
	a_num_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && d_s4.kind == KIND_DIV |->
		(d_s4.rem != '0) && (d_s4.rem < {win.divisor, 8'd0}))
		else $error("window: numerator outside divider range");

endmodule

>>> design/dpw_divide.sv
// ----------------------------------------------------------------------------
// dpw_divide
// Stages 5 to 8: restoring divider, two quotient bits per stage.
// ----------------------------------------------------------------------------
module dpw_divide import dpw_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [DIV_W-1:0] divisor,
	input  logic             in_valid,
	output logic             in_ready,
	input  div_t             in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output div_t             out_data
);

	function automatic div_t div_bit(div_t x, logic [DIV_W-1:0] dv, logic [2:0] b);
		div_t             y;
		logic [NUM_W-1:0] t;
		y = x;
		t = NUM_W'(dv) << b;
		if (y.rem >= t) begin
			y.rem    = y.rem - t;
			y.quo[b] = 1'b1;
		end
		return y;
	endfunction

	logic en_s5, en_s6, en_s7, en_s8;
	logic v_s5, v_s6, v_s7, v_s8;
	div_t d_s5, d_s6, d_s7, d_s8;

	assign en_s8    = !v_s8 || out_ready;
	assign en_s7    = !v_s7 || en_s8;
	assign en_s6    = !v_s6 || en_s7;
	assign en_s5    = !v_s5 || en_s6;
	assign in_ready = en_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else begin
			if (en_s5) begin
				v_s5 <= in_valid;
			end
			if (en_s6) begin
				v_s6 <= v_s5;
			end
			if (en_s7) begin
				v_s7 <= v_s6;
			end
			if (en_s8) begin
				v_s8 <= v_s7;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s5 && in_valid) begin
			d_s5 <= div_bit(div_bit(in_data, divisor, 3'd7), divisor, 3'd6);
		end
		if (en_s6 && v_s5) begin
			d_s6 <= div_bit(div_bit(d_s5, divisor, 3'd5), divisor, 3'd4);
		end
		if (en_s7 && v_s6) begin
			d_s7 <= div_bit(div_bit(d_s6, divisor, 3'd3), divisor, 3'd2);
		end
		if (en_s8 && v_s7) begin
			d_s8 <= div_bit(div_bit(d_s7, divisor, 3'd1), divisor, 3'd0);
		end
	end

	assign out_valid = v_s8;
	assign out_data  = d_s8;

	a_rem_below_div: assert property (@(posedge clk) disable iff (!arst_n)
		v_s8 && d_s8.kind == KIND_DIV |-> d_s8.rem < NUM_W'(divisor))
		else $error("divide: remainder not below divisor");

endmodule

>>> design/dicom_pixel_window_to_gray8.sv
// ----------------------------------------------------------------------------
// dicom_pixel_window_to_gray8
// Raw sample to 8-bit gray: rescale, window/level and optional inversion.
// Pipeline: decode, multiply, add, window, four divider stages and an output
//   register, from sample beat to gray beat.
// Throughput: one beat per cycle; every stage holds under backpressure and
//   bubbles collapse. Derived window limits are registered from the config registers.
// Reset: clears all stage valid bits and loads register defaults.
// ----------------------------------------------------------------------------
module dicom_pixel_window_to_gray8 import dpw_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	dpw_cfg_if.sink       cfg,
	dpw_sample_if.sink    sample,
	dpw_gray_if.source    gray
);

	cfg_t               cfg_q;
	win_t               win_q;
	logic [29:0]        half;
	logic signed [31:0] center32;
	logic signed [31:0] half32;

	logic               v1, r1, v3, r3, v4, r4, v8, r8;
	smp_t               d1;
	res_t               d3;
	div_t               d4, d8;

	logic [GRAY_W-1:0]  gray_nxt;
	logic               en_s9;
	logic               v_s9;
	logic [GRAY_W-1:0]  gray_s9;
	logic               fe_s9;

	// register file
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pixel_format      <= FMT_U16;
			cfg_q.stored_bits       <= 6'd16;
			cfg_q.pad_value         <= 32'sh8000_0000;
			cfg_q.rescale_slope     <= 32'sd1;
			cfg_q.rescale_intercept <= '0;
			cfg_q.window_width      <= '0;
			cfg_q.window_center     <= '0;
			cfg_q.invert_output     <= 1'b0;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_PIXEL_FORMAT:      cfg_q.pixel_format      <= cfg.data[2:0];
				REG_STORED_BITS:       cfg_q.stored_bits       <= cfg.data[5:0];
				REG_PAD_VALUE:         cfg_q.pad_value         <= cfg.data;
				REG_RESCALE_SLOPE:     cfg_q.rescale_slope     <= cfg.data;
				REG_RESCALE_INTERCEPT: cfg_q.rescale_intercept <= cfg.data;
				REG_WINDOW_WIDTH:      cfg_q.window_width      <= cfg.data[30:0];
				REG_WINDOW_CENTER:     cfg_q.window_center     <= cfg.data[30:0];
				REG_INVERT_OUTPUT:     cfg_q.invert_output     <= cfg.data[0];
				default: ;
			endcase
		end
	end

	// window limits: hi = center + half - 1, lo = center - half
	assign half     = cfg_q.window_width[30:1];
	assign center32 = cfg_q.window_center;
	assign half32   = {2'b00, half};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q.hi      <= -32'sd1;
			win_q.lo      <= '0;
			win_q.divisor <= '1;
		end else begin
			win_q.hi      <= center32 + half32 - 32'sd1;
			win_q.lo      <= center32 - half32;
			win_q.divisor <= {half, 1'b0} - DIV_W'(1);
		end
	end

	dpw_decode u_decode (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.in_valid     (sample.valid),
		.in_ready     (sample.ready),
		.raw_sample   (sample.raw_sample),
		.frame_end_in (sample.frame_end_in),
		.out_valid    (v1),
		.out_ready    (r1),
		.out_data     (d1)
	);

	dpw_rescale u_rescale (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (v1),
		.in_ready  (r1),
		.in_data   (d1),
		.out_valid (v3),
		.out_ready (r3),
		.out_data  (d3)
	);

	dpw_window u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.win       (win_q),
		.in_valid  (v3),
		.in_ready  (r3),
		.in_data   (d3),
		.out_valid (v4),
		.out_ready (r4),
		.out_data  (d4)
	);

	dpw_divide u_divide (
		.clk       (clk),
		.arst_n    (arst_n),
		.divisor   (win_q.divisor),
		.in_valid  (v4),
		.in_ready  (r4),
		.in_data   (d4),
		.out_valid (v8),
		.out_ready (r8),
		.out_data  (d8)
	);

	// final select and MONOCHROME1 inversion
	always_comb begin
		case (d8.kind)
			KIND_PASS:  gray_nxt = d8.level;
			KIND_LEVEL: gray_nxt = d8.level;
			KIND_DIV:   gray_nxt = d8.quo;
			default:    gray_nxt = '0;
		endcase
		if (cfg_q.invert_output && (d8.kind == KIND_LEVEL || d8.kind == KIND_DIV)) begin
			gray_nxt = GRAY_MAX - gray_nxt;
		end
	end

	assign en_s9 = !v_s9 || gray.ready;
	assign r8    = en_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s9 <= 1'b0;
		end else if (en_s9) begin
			v_s9 <= v8;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s9 && v8) begin
			gray_s9 <= gray_nxt;
			fe_s9   <= d8.frame_end;
		end
	end

	assign gray.valid         = v_s9;
	assign gray.gray_value    = gray_s9;
	assign gray.frame_end_out = fe_s9;

	// an empty output beat means nothing in the pipe can be stalled
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!gray.valid |-> sample.ready)
		else $error("top: input stalled with empty output");

endmodule
